### sv/sm83_pkg.sv
// ----------------------------------------------------------------------------
// SM83 subset execute package
// Shared types, opcode codes and field widths for the instruction executor.
// ----------------------------------------------------------------------------
package sm83_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CycW   = 2;
  localparam int unsigned FlagW  = 4;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  // Opcodes of the supported subset.
  localparam logic [7:0] OpNop     = 8'h00;
  localparam logic [7:0] OpJrNz    = 8'h20;
  localparam logic [7:0] OpLdCImm  = 8'h0E;
  localparam logic [7:0] OpLdAImm  = 8'h3E;
  localparam logic [7:0] OpLdhCA   = 8'hE2;
  localparam logic [7:0] OpIncC    = 8'h0C;
  localparam logic [7:0] OpLdHlA   = 8'h77;
  localparam logic [7:0] OpLdhImmA = 8'hE0;
  localparam logic [7:0] OpLdDeImm = 8'h11;
  localparam logic [7:0] OpLdHlImm = 8'h21;
  localparam logic [7:0] OpLdSpImm = 8'h31;
  localparam logic [7:0] OpLdHlDec = 8'h32;
  localparam logic [7:0] OpXorA    = 8'hAF;
  localparam logic [7:0] OpLdLB    = 8'h68;
  localparam logic [7:0] OpPrefixCb = 8'hCB;
  localparam logic [7:0] CbBit7H   = 8'h7C;

  localparam logic [7:0] IoPageHigh = 8'hFF;

  // Flag bit positions.
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] d;
    logic [ByteW-1:0] e;
    logic [ByteW-1:0] h;
    logic [ByteW-1:0] l;
    logic [FlagW-1:0] flags;
    logic [WordW-1:0] pc;
    logic [WordW-1:0] sp;
  } arch_t;

  typedef struct packed {
    logic [ByteW-1:0] opcode;
    logic [ByteW-1:0] operand_low;
    logic [ByteW-1:0] operand_high;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] next_pc;
    logic [CycW-1:0]  machine_cycles;
    logic             write_valid;
    logic [WordW-1:0] write_address;
    logic [ByteW-1:0] write_data;
    logic [FlagW-1:0] flags_now;
    logic             status;
  } result_t;

endpackage

### sv/sm83_exec.sv
// ----------------------------------------------------------------------------
// SM83 subset execute logic
// Decodes one instruction and computes the next architectural state and the
// result item from the current state.
// ----------------------------------------------------------------------------
module sm83_exec
  import sm83_pkg::*;
(
  input  arch_t   cur_i,
  input  item_t   item_i,
  output arch_t   nxt_o,
  output result_t res_o
);

  logic [WordW-1:0] hl;
  logic [WordW-1:0] step;
  logic [ByteW-1:0] c_inc;
  logic             bad;

  assign hl    = {cur_i.h, cur_i.l};
  assign c_inc = cur_i.c + 8'd1;

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    step  = '0;
    bad   = 1'b0;
    unique case (item_i.opcode)
      OpNop: begin
        step = 16'd1;
        res_o.machine_cycles = 2'd1;
      end
      OpJrNz: begin
        if (!cur_i.flags[FlagZ]) begin
          step = 16'd2 + {{ByteW{item_i.operand_low[ByteW-1]}}, item_i.operand_low};
          res_o.machine_cycles = 2'd3;
        end else begin
          step = 16'd2;
          res_o.machine_cycles = 2'd2;
        end
      end
      OpLdCImm: begin
        nxt_o.c = item_i.operand_low;
        step = 16'd2;
        res_o.machine_cycles = 2'd2;
      end
      OpLdAImm: begin
        nxt_o.a = item_i.operand_low;
        step = 16'd2;
        res_o.machine_cycles = 2'd2;
      end
      OpLdhCA: begin
        res_o.write_valid   = 1'b1;
        res_o.write_address = {IoPageHigh, cur_i.c};
        res_o.write_data    = cur_i.a;
        step = 16'd1;
        res_o.machine_cycles = 2'd2;
      end
      OpIncC: begin
        nxt_o.c = c_inc;
        nxt_o.flags[FlagZ] = (c_inc == '0);
        nxt_o.flags[FlagN] = 1'b0;
        nxt_o.flags[FlagH] = (cur_i.c[3:0] == 4'hF);
        step = 16'd1;
        res_o.machine_cycles = 2'd1;
      end
      OpLdHlA: begin
        res_o.write_valid   = 1'b1;
        res_o.write_address = hl;
        res_o.write_data    = cur_i.a;
        step = 16'd1;
        res_o.machine_cycles = 2'd2;
      end
      OpLdhImmA: begin
        res_o.write_valid   = 1'b1;
        res_o.write_address = {IoPageHigh, item_i.operand_low};
        res_o.write_data    = cur_i.a;
        step = 16'd2;
        res_o.machine_cycles = 2'd3;
      end
      OpLdDeImm: begin
        nxt_o.d = item_i.operand_high;
        nxt_o.e = item_i.operand_low;
        step = 16'd3;
        res_o.machine_cycles = 2'd3;
      end
      OpLdHlImm: begin
        nxt_o.h = item_i.operand_high;
        nxt_o.l = item_i.operand_low;
        step = 16'd3;
        res_o.machine_cycles = 2'd3;
      end
      OpLdSpImm: begin
        nxt_o.sp = {item_i.operand_high, item_i.operand_low};
        step = 16'd3;
        res_o.machine_cycles = 2'd3;
      end
      OpLdHlDec: begin
        res_o.write_valid   = 1'b1;
        res_o.write_address = hl;
        res_o.write_data    = cur_i.a;
        {nxt_o.h, nxt_o.l}  = hl - 16'd1;
        step = 16'd1;
        res_o.machine_cycles = 2'd2;
      end
      OpXorA: begin
        nxt_o.a     = '0;
        nxt_o.flags = '0;
        nxt_o.flags[FlagZ] = 1'b1;
        step = 16'd1;
        res_o.machine_cycles = 2'd1;
      end
      OpLdLB: begin
        nxt_o.l = cur_i.b;
        step = 16'd1;
        res_o.machine_cycles = 2'd1;
      end
      OpPrefixCb: begin
        if (item_i.operand_low == CbBit7H) begin
          nxt_o.flags[FlagZ] = ~cur_i.h[ByteW-1];
          nxt_o.flags[FlagN] = 1'b0;
          nxt_o.flags[FlagH] = 1'b1;
          step = 16'd2;
          res_o.machine_cycles = 2'd2;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    // An unsupported instruction leaves every register as it was.
    if (bad) begin
      nxt_o = cur_i;
      res_o = '0;
    end else begin
      nxt_o.pc = cur_i.pc + step;
    end
    res_o.next_pc   = nxt_o.pc;
    res_o.flags_now = nxt_o.flags;
    res_o.status    = bad ? StatusBad : StatusOk;
  end

endmodule

### sv/sm83_arch.sv
// ----------------------------------------------------------------------------
// SM83 subset architectural state
// Register file, flags, program counter and stack pointer, updated once per
// executed instruction.
// ----------------------------------------------------------------------------
module sm83_arch
  import sm83_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  update_i,
  input  arch_t nxt_i,
  output arch_t cur_o
);

  arch_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (update_i) begin
      state_q <= nxt_i;
    end
  end

  assign cur_o = state_q;

endmodule

### sv/sm83_boot_subset_execute_top.sv
// ----------------------------------------------------------------------------
// SM83 boot subset execute top level
// A result item passes through the input register and is then executed into the
// result register, from which it is offered to the sink. Throughput: one
// instruction per cycle while the sink does not stall the result register; the
// architectural state is updated in the same edge that loads the result
// register, so the next instruction sees it at once.
// Reset: asynchronous, active low; clears the register file, flags, PC and SP
// and empties the input and result stages.
// ----------------------------------------------------------------------------
module sm83_boot_subset_execute_top
  import sm83_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] opcode, [15:8] operand_low, [23:16] operand_high
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] next_pc, [17:16] machine_cycles, [18] write_valid,
  // [34:19] write_address, [42:35] write_data, [46:43] flags_now, [47] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] status
  output logic                m_axis_tuser
);

  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  logic    exec_en;
  arch_t   cur, nxt;
  result_t res;

  assign exec_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || exec_en;

  assign in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = exec_en ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.opcode       <= s_axis_tdata[7:0];
      in_item_q.operand_low  <= s_axis_tdata[15:8];
      in_item_q.operand_high <= s_axis_tdata[23:16];
    end
    if (exec_en) begin
      out_res_q <= res;
    end
  end

  sm83_arch u_arch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (exec_en),
    .nxt_i    (nxt),
    .cur_o    (cur)
  );

  sm83_exec u_exec (
    .cur_i  (cur),
    .item_i (in_item_q),
    .nxt_o  (nxt),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.flags_now,
                          out_res_q.write_data,
                          out_res_q.write_address,
                          out_res_q.write_valid,
                          out_res_q.machine_cycles,
                          out_res_q.next_pc};
  assign m_axis_tuser  = out_res_q.status;

endmodule

### sv/sm83_chk.sv
// ----------------------------------------------------------------------------
// SM83 subset execute port checker
// Watches the top-level ports for consistency of result items over time.
// ----------------------------------------------------------------------------
module sm83_chk
  import sm83_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // A stalled result item must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  // An unsupported instruction leaves the machine-cycle field clear and writes nothing.
  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == StatusBad) |-> m_axis_tdata[18:16] == 3'd0)
    else $error("unsupported instruction reported cycles or a write");

  // An executed instruction always reports a nonzero machine-cycle count.
  a_ok_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == StatusOk) |-> m_axis_tdata[17:16] != 2'd0)
    else $error("executed instruction reported zero cycles");

  // Without a write, address and data read as zero; the pad bit is zero.
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[18] |-> m_axis_tdata[42:19] == 24'd0 &&
      !m_axis_tdata[47])
    else $error("write fields not zero without a write");

endmodule

bind sm83_boot_subset_execute_top sm83_chk u_sm83_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/tb_sm83_boot_subset_execute_top.sv
// ----------------------------------------------------------------------------
// SM83 boot subset execute testbench
// Runs short directed instruction sequences and then long random instruction
// streams through the executor. A behavioral copy of the architectural state
// predicts every result, and each returned item is checked field by field
// under changing amounts of source idling and sink backpressure.
// ----------------------------------------------------------------------------
module tb_sm83_boot_subset_execute_top;
  import sm83_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomPerPhase = 450;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  arch_t   cpu = '0;
  result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_taken_jumps = 0;
  int n_writes = 0;
  int n_rejected = 0;
  int idle_cycles = 0;

  sm83_boot_subset_execute_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Executes one instruction against the shadow state and returns the result
  // the block should produce for it.
  function automatic result_t execute_instr(input item_t ins);
    result_t     r;
    logic [15:0] hl;
    logic [15:0] step;
    logic [1:0]  cyc;
    logic [3:0]  f;
    logic        bad;
    r    = '0;
    step = '0;
    cyc  = '0;
    bad  = 1'b0;
    hl   = {cpu.h, cpu.l};
    case (ins.opcode)
      OpNop: begin
        step = 16'd1; cyc = 2'd1;
      end
      OpJrNz: begin
        if (!cpu.flags[FlagZ]) begin
          step = 16'd2 + {{8{ins.operand_low[7]}}, ins.operand_low};
          cyc  = 2'd3;
          n_taken_jumps++;
        end else begin
          step = 16'd2; cyc = 2'd2;
        end
      end
      OpLdCImm: begin
        cpu.c = ins.operand_low; step = 16'd2; cyc = 2'd2;
      end
      OpLdAImm: begin
        cpu.a = ins.operand_low; step = 16'd2; cyc = 2'd2;
      end
      OpLdhCA: begin
        r.write_valid   = 1'b1;
        r.write_address = {IoPageHigh, cpu.c};
        r.write_data    = cpu.a;
        step = 16'd1; cyc = 2'd2;
      end
      OpIncC: begin
        f = '0;
        f[FlagC] = cpu.flags[FlagC];
        if (cpu.c[3:0] == 4'hF) f[FlagH] = 1'b1;
        cpu.c = cpu.c + 8'd1;
        if (cpu.c == 8'd0) f[FlagZ] = 1'b1;
        cpu.flags = f;
        step = 16'd1; cyc = 2'd1;
      end
      OpLdHlA: begin
        r.write_valid   = 1'b1;
        r.write_address = hl;
        r.write_data    = cpu.a;
        step = 16'd1; cyc = 2'd2;
      end
      OpLdhImmA: begin
        r.write_valid   = 1'b1;
        r.write_address = {IoPageHigh, ins.operand_low};
        r.write_data    = cpu.a;
        step = 16'd2; cyc = 2'd3;
      end
      OpLdDeImm: begin
        cpu.d = ins.operand_high; cpu.e = ins.operand_low;
        step = 16'd3; cyc = 2'd3;
      end
      OpLdHlImm: begin
        cpu.h = ins.operand_high; cpu.l = ins.operand_low;
        step = 16'd3; cyc = 2'd3;
      end
      OpLdSpImm: begin
        cpu.sp = {ins.operand_high, ins.operand_low};
        step = 16'd3; cyc = 2'd3;
      end
      OpLdHlDec: begin
        r.write_valid   = 1'b1;
        r.write_address = hl;
        r.write_data    = cpu.a;
        hl = hl - 16'd1;
        {cpu.h, cpu.l} = hl;
        step = 16'd1; cyc = 2'd2;
      end
      OpXorA: begin
        cpu.a = '0;
        cpu.flags = '0;
        cpu.flags[FlagZ] = 1'b1;
        step = 16'd1; cyc = 2'd1;
      end
      OpLdLB: begin
        cpu.l = cpu.b; step = 16'd1; cyc = 2'd1;
      end
      OpPrefixCb: begin
        if (ins.operand_low == CbBit7H) begin
          f = '0;
          f[FlagC] = cpu.flags[FlagC];
          f[FlagH] = 1'b1;
          f[FlagZ] = ~cpu.h[7];
          cpu.flags = f;
          step = 16'd2; cyc = 2'd2;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    // A rejected opcode leaves the whole state untouched.
    if (!bad) cpu.pc = cpu.pc + step;
    r.next_pc        = cpu.pc;
    r.machine_cycles = bad ? 2'd0 : cyc;
    r.flags_now      = cpu.flags;
    r.status         = bad ? StatusBad : StatusOk;
    return r;
  endfunction

  function automatic logic [7:0] supported_op(input int k);
    case (k)
      0:       return OpNop;
      1:       return OpJrNz;
      2:       return OpLdCImm;
      3:       return OpLdAImm;
      4:       return OpLdhCA;
      5:       return OpIncC;
      6:       return OpLdHlA;
      7:       return OpLdhImmA;
      8:       return OpLdDeImm;
      9:       return OpLdHlImm;
      10:      return OpLdSpImm;
      11:      return OpLdHlDec;
      12:      return OpXorA;
      default: return OpLdLB;
    endcase
  endfunction

  // Mostly valid instructions with random operands, some prefixed ones and a
  // share of arbitrary opcode bytes, most of which the block must reject.
  function automatic item_t random_instr();
    item_t ins;
    int    k;
    ins.operand_low  = 8'($urandom_range(0, 255));
    ins.operand_high = 8'($urandom_range(0, 255));
    k = $urandom_range(0, 19);
    if (k < 14) begin
      ins.opcode = supported_op(k);
    end else if (k < 16) begin
      ins.opcode = OpPrefixCb;
      ins.operand_low = CbBit7H;
    end else if (k == 16) begin
      ins.opcode = OpPrefixCb;
    end else begin
      ins.opcode = 8'($urandom_range(0, 255));
    end
    return ins;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic send_instr(input logic [7:0] op, input logic [7:0] lo,
                            input logic [7:0] hi);
    item_t ins;
    ins.opcode       = op;
    ins.operand_low  = lo;
    ins.operand_high = hi;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(execute_instr(ins));
    n_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_jumps();
    send_instr(OpNop, 8'h00, 8'h00);
    // Most negative offset from near zero wraps down, the largest forward
    // offset from the top of memory wraps back up.
    send_instr(OpJrNz, 8'h80, 8'h00);
    send_instr(OpJrNz, 8'h7F, 8'hFF);
  endtask

  task automatic test_flag_updates();
    send_instr(OpLdCImm, 8'h0F, 8'h00);
    send_instr(OpIncC, 8'h00, 8'h00);
    send_instr(OpLdCImm, 8'hFF, 8'h00);
    send_instr(OpIncC, 8'h00, 8'h00);
    send_instr(OpJrNz, 8'h10, 8'h00);
    send_instr(OpLdHlImm, 8'h00, 8'hFF);
    send_instr(OpPrefixCb, CbBit7H, 8'h00);
    send_instr(OpLdHlImm, 8'hFF, 8'h7F);
    send_instr(OpPrefixCb, CbBit7H, 8'h00);
    send_instr(OpXorA, 8'h00, 8'h00);
  endtask

  task automatic test_memory_writes();
    send_instr(OpLdAImm, 8'hFF, 8'h00);
    send_instr(OpLdhCA, 8'h00, 8'h00);
    send_instr(OpLdhImmA, 8'hFF, 8'h00);
    send_instr(OpLdHlImm, 8'h00, 8'h00);
    send_instr(OpLdHlDec, 8'h00, 8'h00);
    send_instr(OpLdHlA, 8'h00, 8'h00);
  endtask

  task automatic test_register_loads();
    send_instr(OpLdDeImm, 8'hFF, 8'hFF);
    send_instr(OpLdSpImm, 8'hFF, 8'hFF);
    send_instr(OpLdLB, 8'h00, 8'h00);
  endtask

  task automatic test_unsupported_opcodes();
    send_instr(OpPrefixCb, 8'h00, 8'h00);
    send_instr(OpPrefixCb, 8'hFF, 8'hFF);
    send_instr(8'hFF, 8'h00, 8'h00);
    send_instr(8'hD3, 8'h55, 8'hAA);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    item_t ins;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < RandomPerPhase; i++) begin
      ins = random_instr();
      send_instr(ins.opcode, ins.operand_low, ins.operand_high);
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.next_pc        = m_axis_tdata[15:0];
      got.machine_cycles = m_axis_tdata[17:16];
      got.write_valid    = m_axis_tdata[18];
      got.write_address  = m_axis_tdata[34:19];
      got.write_data     = m_axis_tdata[42:35];
      got.flags_now      = m_axis_tdata[46:43];
      got.status         = m_axis_tuser;
      if (pending_results.size() == 0) begin
        report("result arrived with no instruction outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.next_pc !== want.next_pc)
          report($sformatf("item %0d next_pc 0x%0h, want 0x%0h",
                           n_checked, got.next_pc, want.next_pc));
        if (got.machine_cycles !== want.machine_cycles)
          report($sformatf("item %0d machine_cycles %0d, want %0d",
                           n_checked, got.machine_cycles, want.machine_cycles));
        if (got.write_valid !== want.write_valid)
          report($sformatf("item %0d write_valid %0b, want %0b",
                           n_checked, got.write_valid, want.write_valid));
        if (got.write_address !== want.write_address)
          report($sformatf("item %0d write_address 0x%0h, want 0x%0h",
                           n_checked, got.write_address, want.write_address));
        if (got.write_data !== want.write_data)
          report($sformatf("item %0d write_data 0x%0h, want 0x%0h",
                           n_checked, got.write_data, want.write_data));
        if (got.flags_now !== want.flags_now)
          report($sformatf("item %0d flags_now 0x%0h, want 0x%0h",
                           n_checked, got.flags_now, want.flags_now));
        if (got.status !== want.status)
          report($sformatf("item %0d status %0b, want %0b",
                           n_checked, got.status, want.status));
        if (want.write_valid) n_writes++;
        if (want.status == StatusBad) n_rejected++;
      end
      n_checked++;
    end
  end

  // Ends the run when neither side has moved an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_jumps();
    test_flag_updates();
    test_memory_writes();
    test_register_loads();
    test_unsupported_opcodes();
    test_random_traffic(0, 0);
    test_random_traffic(64, 0);
    test_random_traffic(0, 64);
    test_random_traffic(14, 14);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Executed %0d instructions, checked %0d results: %0d taken jumps,",
             n_sent, n_checked, n_taken_jumps);
    $display("%0d memory writes and %0d rejected opcodes under four backpressure mixes.",
             n_writes, n_rejected);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/sm83_pkg.sv
sv/sm83_exec.sv
sv/sm83_arch.sv
sv/sm83_boot_subset_execute_top.sv
sv/sm83_chk.sv
tb/tb_sm83_boot_subset_execute_top.sv
